// ----- sv/acsd_pkg.sv -----
// shared types, opcodes and constants for the carry/shift/divide alu
package acsd_pkg;

  localparam int W = 64;
  localparam int NCELL = 64;

  typedef enum logic [4:0] {
    OP_ADD  = 5'd0,
    OP_SUB  = 5'd1,
    OP_SHL  = 5'd2,
    OP_SRA  = 5'd3,
    OP_SRL  = 5'd4,
    OP_GT   = 5'd5,
    OP_GE   = 5'd6,
    OP_UGT  = 5'd7,
    OP_UGE  = 5'd8,
    OP_UDIV = 5'd9,
    OP_DIV  = 5'd10,
    OP_UMOD = 5'd11,
    OP_MOD  = 5'd12,
    OP_UDIV64 = 5'd13,
    OP_DIV64  = 5'd14,
    OP_UMOD64 = 5'd15,
    OP_MOD64  = 5'd16
  } op_t;

  // per-transaction data that travels down the divider chain
  typedef struct packed {
    logic        vld;
    logic        want_rem;
    logic        neg_q;
    logic        neg_r;
    logic        byp;
    logic        wide;
    logic [W-1:0] byp_val;
    logic [W-1:0] rem;
    logic [W-1:0] quo;
    logic [W-1:0] dvs;
  } dslot_t;

endpackage

// ----- sv/acsd_cell.sv -----
// one restoring division step with its pipeline register
module acsd_cell (
  input  logic            clk,
  input  logic            rst_n,
  input  acsd_pkg::dslot_t d_in,
  output acsd_pkg::dslot_t d_out
);

  acsd_pkg::dslot_t s_r, s_nxt;
  logic [acsd_pkg::W:0] part;
  logic [acsd_pkg::W:0] diff;

  always_comb begin
    s_nxt = d_in;
    part = {d_in.rem, d_in.quo[acsd_pkg::W-1]};
    diff = part - {1'b0, d_in.dvs};
    s_nxt.quo = {d_in.quo[acsd_pkg::W-2:0], ~diff[acsd_pkg::W]};
    s_nxt.rem = diff[acsd_pkg::W] ? part[acsd_pkg::W-1:0] : diff[acsd_pkg::W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s_r.vld <= 1'b0;
    end else begin
      s_r.vld <= s_nxt.vld;
    end
    s_r.want_rem <= s_nxt.want_rem;
    s_r.neg_q    <= s_nxt.neg_q;
    s_r.neg_r    <= s_nxt.neg_r;
    s_r.byp      <= s_nxt.byp;
    s_r.wide     <= s_nxt.wide;
    s_r.byp_val  <= s_nxt.byp_val;
    s_r.rem      <= s_nxt.rem;
    s_r.quo      <= s_nxt.quo;
    s_r.dvs      <= s_nxt.dvs;
  end

  assign d_out = s_r;

endmodule

// ----- sv/alu_carry_shift_divide_top.sv -----
// top level: combinational alu ops plus a 64-cell pipelined divider
// One transaction is accepted every cycle (busy is always low). Every result, whether add,
// subtract, shift, compare, divide or modulo, passes through the entry register, the 64-cell
// restoring divider chain and the exit register; quick results wait in a matching delay
// line. Results leave in the order that transactions came in; out_valid pulses for one cycle
// and the receiver cannot stall the block.
module alu_carry_shift_divide_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [4:0]  in_op,
  input  logic [63:0] in_operand_a,
  input  logic [63:0] in_operand_b,
  input  logic        in_carry_in,
  output logic        out_valid,
  output logic [63:0] out_main_value,
  output logic [31:0] out_high_part
);

  localparam int W = acsd_pkg::W;
  localparam int N = acsd_pkg::NCELL;

  acsd_pkg::dslot_t chain [0:N];
  acsd_pkg::dslot_t ent_r, ent_nxt;

  logic [W-1:0] mv;
  logic [31:0]  hv;
  logic [31:0]  a, b;
  logic [32:0]  s;
  logic [5:0]   sh;
  logic [63:0]  dl, dr;
  logic         sdiv, wide, na, nb;
  logic [W-1:0] ea, eb, ma, mb;
  logic         go;

  // quick-path delay line so quick results line up with divider results
  logic         qv_r [0:N];
  logic [W-1:0] qm_r [0:N];
  logic [31:0]  qh_r [0:N];

  logic         ov_r;
  logic [W-1:0] om_r;
  logic [31:0]  oh_r;

  assign busy = 1'b0;
  assign go = start;
  assign a = in_operand_a[31:0];
  assign b = in_operand_b[31:0];

  always_comb begin
    mv = '0;
    hv = '0;
    s  = '0;
    sh = (b >= 32'd32) ? 6'd32 : {1'b0, b[4:0]};
    dl = '0;
    dr = '0;
    case (in_op)
      acsd_pkg::OP_ADD: begin
        s = {1'b0, a} + {1'b0, b} + {32'd0, in_carry_in};
        mv = {32'd0, s[31:0]};
        hv = {31'd0, s[32]};
      end
      acsd_pkg::OP_SUB: begin
        s = {1'b0, a} + {1'b0, ~b} + {32'd0, in_carry_in};
        mv = {32'd0, s[31:0]};
        hv = {31'd0, s[32]};
      end
      acsd_pkg::OP_SHL: begin
        dl = {32'd0, a} << sh;
        if (b == 32'd0) begin
          mv = {32'd0, a};
        end else begin
          mv = {32'd0, dl[31:1], dl[0] | in_carry_in};
          hv = dl[63:32];
        end
      end
      acsd_pkg::OP_SRA, acsd_pkg::OP_SRL: begin
        dr = {((in_op == acsd_pkg::OP_SRA) && a[31]) ? 32'hffffffff : 32'd0, a};
        dr = {dr[63:32], a} >> sh;
        dl = {a, 32'd0} >> sh;
        if (b == 32'd0) begin
          mv = {32'd0, a};
        end else begin
          hv = dl[31:0];
          if (in_op == acsd_pkg::OP_SRA) begin
            mv = {32'd0, ((a[31] && sh != 6'd0) ? ~(32'hffffffff >> sh) : 32'd0) | dr[31:0]};
          end else begin
            mv = {32'd0, dr[31:1], dr[0] | in_carry_in};
          end
        end
      end
      acsd_pkg::OP_GT:  mv = {63'd0, $signed(a) > $signed(b)};
      acsd_pkg::OP_GE:  mv = {63'd0, $signed(a) >= $signed(b)};
      acsd_pkg::OP_UGT: mv = {63'd0, a > b};
      acsd_pkg::OP_UGE: mv = {63'd0, a >= b};
      default: begin
        mv = '0;
      end
    endcase
  end

  always_comb begin
    wide = (in_op >= acsd_pkg::OP_UDIV64) && (in_op <= acsd_pkg::OP_MOD64);
    sdiv = (in_op == acsd_pkg::OP_DIV) || (in_op == acsd_pkg::OP_MOD) ||
           (in_op == acsd_pkg::OP_DIV64) || (in_op == acsd_pkg::OP_MOD64);
    ea = wide ? in_operand_a : {{32{sdiv & a[31]}}, a};
    eb = wide ? in_operand_b : {{32{sdiv & b[31]}}, b};
    na = sdiv & ea[W-1];
    nb = sdiv & eb[W-1];
    ma = na ? (~ea + 64'd1) : ea;
    mb = nb ? (~eb + 64'd1) : eb;
    ent_nxt.vld      = go && (in_op >= acsd_pkg::OP_UDIV) && (in_op <= acsd_pkg::OP_MOD64);
    ent_nxt.want_rem = (in_op == acsd_pkg::OP_UMOD) || (in_op == acsd_pkg::OP_MOD) ||
                       (in_op == acsd_pkg::OP_UMOD64) || (in_op == acsd_pkg::OP_MOD64);
    ent_nxt.neg_q    = na ^ nb;
    ent_nxt.neg_r    = na;
    ent_nxt.byp      = (eb == 64'd0);
    ent_nxt.wide     = wide;
    ent_nxt.byp_val  = wide ? in_operand_a : {32'd0, a};
    ent_nxt.rem      = '0;
    ent_nxt.quo      = ma;
    ent_nxt.dvs      = mb;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ent_r.vld <= 1'b0;
    end else begin
      ent_r.vld <= ent_nxt.vld;
    end
    ent_r.want_rem <= ent_nxt.want_rem;
    ent_r.neg_q    <= ent_nxt.neg_q;
    ent_r.neg_r    <= ent_nxt.neg_r;
    ent_r.byp      <= ent_nxt.byp;
    ent_r.wide     <= ent_nxt.wide;
    ent_r.byp_val  <= ent_nxt.byp_val;
    ent_r.rem      <= ent_nxt.rem;
    ent_r.quo      <= ent_nxt.quo;
    ent_r.dvs      <= ent_nxt.dvs;
  end

  assign chain[0] = ent_r;

  for (genvar i = 0; i < N; i++) begin : g_cell
    acsd_cell u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .d_in  (chain[i]),
      .d_out (chain[i+1])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i <= N; i++) begin
        qv_r[i] <= 1'b0;
      end
    end else begin
      qv_r[0] <= go;
      for (int i = 1; i <= N; i++) begin
        qv_r[i] <= qv_r[i-1];
      end
    end
    qm_r[0] <= mv;
    qh_r[0] <= hv;
    for (int i = 1; i <= N; i++) begin
      qm_r[i] <= qm_r[i-1];
      qh_r[i] <= qh_r[i-1];
    end
  end

  // the delay line and the divider chain have equal length, so slots stay in order
  logic [W-1:0] q_fin, r_fin, d_fin;
  always_comb begin
    q_fin = chain[N].neg_q ? (~chain[N].quo + 64'd1) : chain[N].quo;
    r_fin = chain[N].neg_r ? (~chain[N].rem + 64'd1) : chain[N].rem;
    d_fin = chain[N].want_rem ? r_fin : q_fin;
    if (!chain[N].wide) begin
      d_fin = {32'd0, d_fin[31:0]};
    end
    if (chain[N].byp) begin
      d_fin = chain[N].byp_val;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_r <= 1'b0;
    end else begin
      ov_r <= qv_r[N];
    end
    om_r <= chain[N].vld ? d_fin : qm_r[N];
    oh_r <= chain[N].vld ? 32'd0 : qh_r[N];
  end

  assign out_valid      = ov_r;
  assign out_main_value = om_r;
  assign out_high_part  = oh_r;

endmodule

// ----- sv/acsd_checker.sv -----
// port-level checks for the alu, bound to the top level
module acsd_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        start,
  input logic        busy,
  input logic        out_valid,
  input logic [31:0] out_high_part
);

  a_never_busy: assert property (@(posedge clk) disable iff (!rst_n) !busy)
    else $error("busy raised");

  a_known_out: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !$isunknown(out_high_part))
    else $error("high part unknown on result");

  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##66 out_valid)
    else $error("result missing");

  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    ##66 (out_valid |-> $past(start, 66)))
    else $error("result without transaction");

endmodule

bind alu_carry_shift_divide_top acsd_checker u_acsd_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .start         (start),
  .busy          (busy),
  .out_valid     (out_valid),
  .out_high_part (out_high_part)
);
